[rtl/core/sas_pkg.sv]
package sas_pkg;

	localparam int FUNC_W  = 3;
	localparam int INDEX_W = 4;
	localparam int DELTA_W = 16;
	localparam int SPEED_W = 16;
	localparam int DUR_W   = 16;
	localparam int CNT_W   = 9;
	localparam int IN_CW   = 12;
	localparam int POS_W   = 8;
	localparam int ACC_W   = 34;
	localparam int RECT_W  = 20;
	localparam int SIZE_W  = 12;
	localparam int STAT_W  = 2;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;
	localparam logic [CNT_W-1:0]   CNT_MAX     = 9'd256;

	typedef enum logic [0:0] {
		REG_SPEED  = 1'b0,
		REG_GLOBAL = 1'b1
	} reg_idx_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_TICK     = 3'd0,
		FN_PLAY     = 3'd1,
		FN_PLAY_IDX = 3'd2,
		FN_PAUSE    = 3'd3,
		FN_STOP     = 3'd4,
		FN_LOAD     = 3'd5
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_BADIDX = 2'd1,
		STAT_REJECT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_ACC,
		S_MOD,
		S_RECT,
		S_PLACE
	} seq_state_t;

endpackage

[rtl/core/sas_ram.sv]
module sas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/sas_div.sv]
module sas_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sas_pkg::CNT_W-1:0]  dividend,
	input  logic [sas_pkg::CNT_W-1:0]  divisor,
	output logic                       done,
	output logic [sas_pkg::CNT_W-1:0]  quo,
	output logic [sas_pkg::CNT_W-1:0]  rem
);
	import sas_pkg::*;

	localparam int CW = $clog2(CNT_W + 1);

	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] quo_q;
	logic [CNT_W-1:0] den_q;
	logic [CNT_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, quo_q[CNT_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(CNT_W);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (run_q) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, den_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[CNT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

[rtl/core/sprite_animation_sequencer_unit.sv]
// Sprite sheet animation sequencer. Pulse start while busy is low to transfer
// one command; exactly one result follows, shown for one cycle with done high,
// and the receiver must take it then. The animation table and the per-entry
// frame position and time accumulator live in two single-port-write RAMs with
// registered reads. Play, pause, stop, load, unused codes and a tick that is
// not playing or runs at zero speed end after the dispatch state; a playing
// tick that does not advance passes the accumulate state, a tick that advances
// the accumulate, modulo, rectangle and place states, and a valid play index
// the rectangle and place states, waiting on the serial divider, nine iterations
// per division, run twice per advance (frame index modulo count, then column
// and row) and once per play index. A new command can be taken in the cycle in
// which done is high. Speed and global timer mode sit at APB byte addresses 0
// and 4; the user must write them only while idle, which the block does not enforce.
module sprite_animation_sequencer_unit #(
	parameter int MAX_ANIMS  = 16,
	parameter int COORD_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sas_pkg::APB_AW-1:0]   paddr,
	input  logic [sas_pkg::APB_DW-1:0]   pwdata,
	output logic [sas_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic [sas_pkg::FUNC_W-1:0]   func,
	input  logic [sas_pkg::INDEX_W-1:0]  anim_index,
	input  logic [sas_pkg::DELTA_W-1:0]  delta_time,
	input  logic [sas_pkg::DUR_W-1:0]    frame_duration,
	input  logic [sas_pkg::CNT_W-1:0]    frame_count,
	input  logic [sas_pkg::CNT_W-1:0]    column_count,
	input  logic [sas_pkg::IN_CW-1:0]    origin_x,
	input  logic [sas_pkg::IN_CW-1:0]    origin_y,
	input  logic [sas_pkg::IN_CW-1:0]    frame_w,
	input  logic [sas_pkg::IN_CW-1:0]    frame_h,
	output logic                         done,
	output logic [sas_pkg::RECT_W-1:0]   rect_left,
	output logic [sas_pkg::RECT_W-1:0]   rect_top,
	output logic [sas_pkg::SIZE_W-1:0]   rect_width,
	output logic [sas_pkg::SIZE_W-1:0]   rect_height,
	output logic                         rect_changed,
	output logic                         playing,
	output logic [sas_pkg::STAT_W-1:0]   status
);
	import sas_pkg::*;

	localparam int AW   = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
	localparam int EW   = $clog2(MAX_ANIMS + 1);
	localparam int CMPW = (EW > INDEX_W) ? EW : INDEX_W;
	localparam int GW   = (COORD_BITS < IN_CW) ? COORD_BITS : IN_CW;
	localparam int ENT_W = 4 * GW + DUR_W + 2 * CNT_W;
	localparam int ST_W  = POS_W + ACC_W;
	localparam int PROD_W = GW + CNT_W;

	// config
	logic [SPEED_W-1:0] speed_q;
	logic               glob_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= SPEED_RESET;
			glob_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[2]))
				REG_SPEED:  speed_q <= pwdata[SPEED_W-1:0];
				REG_GLOBAL: glob_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_SPEED:  prdata = {{(APB_DW-SPEED_W){1'b0}}, speed_q};
			REG_GLOBAL: prdata = {{(APB_DW-1){1'b0}}, glob_q};
			default:    prdata = '0;
		endcase
	end

	// state
	seq_state_t         state_q, state_d;
	logic               done_q, done_d;
	logic               playing_q;
	logic [INDEX_W-1:0] cur_q;
	logic [EW-1:0]      loaded_q;
	logic [POS_W-1:0]   shpos_q;
	logic [ACC_W-1:0]   shacc_q;
	logic [RECT_W-1:0]  left_q, top_q;
	logic [SIZE_W-1:0]  w_q, h_q;
	status_t            status_q;
	logic               changed_q;

	func_t              func_q;
	logic [INDEX_W-1:0] idx_q;
	logic [AW-1:0]      addr_q;
	logic [31:0]        add_q;
	logic [ACC_W-1:0]   acc_q;
	logic [POS_W-1:0]   pos_q;
	logic [PROD_W-1:0]  prodx_q, prody_q;

	logic accept;
	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// addressing
	logic [AW+INDEX_W-1:0] cur_ext, idx_ext;
	logic [AW+EW-1:0]      ld_ext;
	logic [AW-1:0]         rd_addr_in, raddr;

	assign cur_ext = {{AW{1'b0}}, cur_q};
	assign idx_ext = {{AW{1'b0}}, anim_index};
	assign ld_ext  = {{AW{1'b0}}, loaded_q};
	assign rd_addr_in = (func_t'(func) == FN_PLAY_IDX) ? idx_ext[AW-1:0] : cur_ext[AW-1:0];
	assign raddr = (state_q == S_IDLE) ? rd_addr_in : addr_q;

	// load check
	logic           load_ok;
	logic [CNT_W-1:0] cnt_sat;
	assign cnt_sat = frame_count[CNT_W-1] ? CNT_MAX : frame_count;
	assign load_ok = (frame_count != '0) && (column_count != '0) &&
		(loaded_q < EW'(MAX_ANIMS));

	// memories
	logic             ent_we;
	logic [ENT_W-1:0] ent_wdata, ent_rd;
	logic             st_we;
	logic [AW-1:0]    st_waddr;
	logic [ST_W-1:0]  st_wdata, st_rd;

	assign ent_we    = accept && (func_t'(func) == FN_LOAD) && load_ok;
	assign ent_wdata = {origin_x[GW-1:0], origin_y[GW-1:0], frame_w[GW-1:0],
		frame_h[GW-1:0], frame_duration, cnt_sat, column_count};

	sas_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ANIMS)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ld_ext[AW-1:0]),
		.wdata (ent_wdata),
		.raddr (raddr),
		.rdata (ent_rd)
	);

	sas_ram #(.WIDTH(ST_W), .DEPTH(MAX_ANIMS)) u_st_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (raddr),
		.rdata (st_rd)
	);

	logic [GW-1:0]    e_ox, e_oy, e_fw, e_fh;
	logic [DUR_W-1:0] e_dur;
	logic [CNT_W-1:0] e_cnt, e_cols;
	assign {e_ox, e_oy, e_fw, e_fh, e_dur, e_cnt, e_cols} = ent_rd;

	logic [POS_W-1:0] pos_src;
	logic [ACC_W-1:0] acc_src;
	assign pos_src = glob_q ? shpos_q : st_rd[ST_W-1:ACC_W];
	assign acc_src = glob_q ? shacc_q : st_rd[ACC_W-1:0];

	logic [ACC_W:0]   acc_sum;
	logic [ACC_W-1:0] acc_sat, lim;
	assign acc_sum = {1'b0, acc_src} + (ACC_W+1)'(add_q);
	assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
	assign lim     = ACC_W'({e_dur, 8'd0});

	logic cur_ok, idx_ok, tick_go, advance;
	assign cur_ok  = CMPW'(cur_q) < CMPW'(loaded_q);
	assign idx_ok  = CMPW'(idx_q) < CMPW'(loaded_q);
	assign tick_go = playing_q && cur_ok && (speed_q != '0);
	assign advance = acc_q >= lim;

	// divider
	logic             div_start, div_done;
	logic [CNT_W-1:0] div_a, div_b, div_quo, div_rem;

	sas_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) state_d = S_DISPATCH;
			S_DISPATCH: begin
				case (func_q)
					FN_TICK:     state_d = tick_go ? S_ACC : S_IDLE;
					FN_PLAY_IDX: state_d = idx_ok ? S_RECT : S_IDLE;
					default:     state_d = S_IDLE;
				endcase
			end
			S_ACC:   state_d = advance ? S_MOD : S_IDLE;
			S_MOD:   if (div_done) state_d = S_RECT;
			S_RECT:  if (div_done) state_d = S_PLACE;
			S_PLACE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		st_we     = 1'b0;
		st_waddr  = addr_q;
		st_wdata  = '0;
		div_start = 1'b0;
		div_a     = '0;
		div_b     = e_cols;
		done_d    = (state_q != S_IDLE) && (state_d == S_IDLE);
		case (state_q)
			S_IDLE: begin
				st_we    = ent_we;
				st_waddr = ld_ext[AW-1:0];
			end
			S_DISPATCH: begin
				if (func_q == FN_STOP && cur_ok && !glob_q) begin
					st_we = 1'b1;
				end
				if (func_q == FN_PLAY_IDX && idx_ok) begin
					div_start = 1'b1;
					div_a     = CNT_W'(pos_src);
				end
			end
			S_ACC: begin
				if (advance) begin
					div_start = 1'b1;
					div_a     = CNT_W'(pos_src) + 1'b1;
					div_b     = e_cnt;
				end else begin
					st_we    = !glob_q;
					st_wdata = {pos_src, acc_q};
				end
			end
			S_MOD: begin
				if (div_done) begin
					div_start = 1'b1;
					div_a     = div_rem;
				end
			end
			S_PLACE: begin
				st_we    = (func_q == FN_TICK) && !glob_q;
				st_wdata = {pos_q, acc_q};
			end
			default: ;
		endcase
	end

	logic [PROD_W:0] left_sum, top_sum;
	assign left_sum = (PROD_W+1)'(e_ox) + (PROD_W+1)'(prodx_q);
	assign top_sum  = (PROD_W+1)'(e_oy) + (PROD_W+1)'(prody_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_q    <= 1'b0;
			playing_q <= 1'b0;
			cur_q     <= '0;
			loaded_q  <= '0;
			shpos_q   <= '0;
			shacc_q   <= '0;
			left_q    <= '0;
			top_q     <= '0;
			w_q       <= '0;
			h_q       <= '0;
			status_q  <= STAT_OK;
			changed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						changed_q <= 1'b0;
						status_q  <= STAT_OK;
						if (func_t'(func) == FN_LOAD) begin
							if (load_ok) begin
								loaded_q <= loaded_q + 1'b1;
							end else begin
								status_q <= STAT_REJECT;
							end
						end
					end
				end
				S_DISPATCH: begin
					case (func_q)
						FN_PLAY: begin
							if (loaded_q != '0) playing_q <= 1'b1;
							else status_q <= STAT_BADIDX;
						end
						FN_PLAY_IDX: if (!idx_ok) status_q <= STAT_BADIDX;
						FN_PAUSE: playing_q <= 1'b0;
						FN_STOP: begin
							if (!cur_ok) begin
								status_q <= STAT_BADIDX;
							end else begin
								playing_q <= 1'b0;
								if (glob_q) begin
									shpos_q <= '0;
									shacc_q <= '0;
								end
							end
						end
						default: ;
					endcase
				end
				S_ACC: if (!advance && glob_q) shacc_q <= acc_q;
				S_PLACE: begin
					left_q    <= left_sum[RECT_W-1:0];
					top_q     <= top_sum[RECT_W-1:0];
					changed_q <= 1'b1;
					if (func_q == FN_TICK) begin
						if (glob_q) begin
							shpos_q <= pos_q;
							shacc_q <= acc_q;
						end
					end else begin
						w_q       <= SIZE_W'(e_fw);
						h_q       <= SIZE_W'(e_fh);
						cur_q     <= idx_q;
						playing_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(func);
			idx_q  <= anim_index;
			addr_q <= rd_addr_in;
			add_q  <= delta_time * speed_q;
		end
		if (state_q == S_DISPATCH) begin
			acc_q <= acc_sat;
		end else if (state_q == S_ACC && advance) begin
			acc_q <= acc_q - lim;
		end
		if (state_q == S_MOD && div_done) begin
			pos_q <= div_rem[POS_W-1:0];
		end
		if (state_q == S_RECT && div_done) begin
			prodx_q <= PROD_W'(e_fw) * PROD_W'(div_rem);
			prody_q <= PROD_W'(e_fh) * PROD_W'(div_quo);
		end
	end

	assign done         = done_q;
	assign rect_left    = left_q;
	assign rect_top     = top_q;
	assign rect_width   = w_q;
	assign rect_height  = h_q;
	assign rect_changed = changed_q;
	assign playing      = playing_q;
	assign status       = status_q;

`ifndef NO_ASSERTIONS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done) else $error("transfer not started");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result held more than one cycle");
	a_loaded_range: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= EW'(MAX_ANIMS)) else $error("table count overflow");
	a_change_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && rect_changed |-> status == STAT_OK) else $error("changed with error");
`endif

endmodule
